FILE: src/lst_pkg.sv
// ----------------------------------------------------------------------------
// LED star twinkle package
// Shared types, register addresses and constants for the star renderer.
// ----------------------------------------------------------------------------
package lst_pkg;

  localparam int MaxLeds = 64;
  localparam int LedW    = $clog2(MaxLeds);
  localparam int LenW    = 7;
  localparam int AddrW   = 5;

  // Register byte addresses.
  localparam logic [AddrW-1:0] RegFade   = 5'd0;
  localparam logic [AddrW-1:0] RegHold   = 5'd4;
  localparam logic [AddrW-1:0] RegRed    = 5'd8;
  localparam logic [AddrW-1:0] RegGreen  = 5'd12;
  localparam logic [AddrW-1:0] RegBlue   = 5'd16;
  localparam logic [AddrW-1:0] RegThresh = 5'd20;
  localparam logic [AddrW-1:0] RegLen    = 5'd24;

  typedef struct packed {
    logic [31:0] frame_ms;
    logic [9:0]  spawn_draw;
    logic [5:0]  spawn_led;
  } in_item_t;

  typedef struct packed {
    logic [5:0] led_index;
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
    logic       frame_last;
  } out_item_t;

  // Job handed from the front end to the back end, one per LED.
  typedef struct packed {
    logic [LedW-1:0] led;
    logic            lit;
    logic            full;
    logic [15:0]     num;
    logic            last;
  } job_t;

endpackage

FILE: src/led_star_twinkle_renderer.sv
// A fading LED holds the back end for three divides, one per colour channel; others skip
// the divider. The back end takes no new job until its current pixel is loaded for output.
// Reset (rst_n low, synchronous) clears all stars and loads the register defaults.
// ----------------------------------------------------------------------------
// LED star twinkle renderer
// Top level: configuration registers, front end and back end.
// ----------------------------------------------------------------------------
module led_star_twinkle_renderer (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  lst_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output lst_pkg::out_item_t        out_data,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [lst_pkg::AddrW-1:0] cfg_paddr,
  input  logic [31:0]               cfg_pwdata,
  output logic [31:0]               cfg_prdata,
  output logic                      cfg_pready
);

  logic [15:0]              fade_r, hold_r;
  logic [7:0]               red_r, green_r, blue_r;
  logic [10:0]              thresh_r;
  logic [lst_pkg::LenW-1:0] len_r;
  logic                     job_valid, job_stall;
  lst_pkg::job_t            job;

  assign cfg_pready = 1'b1;

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fade_r   <= 16'd500;
      hold_r   <= 16'd1000;
      red_r    <= 8'd255;
      green_r  <= 8'd255;
      blue_r   <= 8'd255;
      thresh_r <= 11'd102;
      len_r    <= 7'd64;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (cfg_paddr)
        lst_pkg::RegFade:   fade_r   <= cfg_pwdata[15:0];
        lst_pkg::RegHold:   hold_r   <= cfg_pwdata[15:0];
        lst_pkg::RegRed:    red_r    <= cfg_pwdata[7:0];
        lst_pkg::RegGreen:  green_r  <= cfg_pwdata[7:0];
        lst_pkg::RegBlue:   blue_r   <= cfg_pwdata[7:0];
        lst_pkg::RegThresh: thresh_r <= cfg_pwdata[10:0];
        lst_pkg::RegLen:    len_r    <= cfg_pwdata[6:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (cfg_paddr)
      lst_pkg::RegFade:   cfg_prdata = 32'(fade_r);
      lst_pkg::RegHold:   cfg_prdata = 32'(hold_r);
      lst_pkg::RegRed:    cfg_prdata = 32'(red_r);
      lst_pkg::RegGreen:  cfg_prdata = 32'(green_r);
      lst_pkg::RegBlue:   cfg_prdata = 32'(blue_r);
      lst_pkg::RegThresh: cfg_prdata = 32'(thresh_r);
      lst_pkg::RegLen:    cfg_prdata = 32'(len_r);
      default:            cfg_prdata = '0;
    endcase
  end

  lst_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .fade      (fade_r),
    .hold      (hold_r),
    .thresh    (thresh_r),
    .len       (len_r),
    .job_valid (job_valid),
    .job_stall (job_stall),
    .job       (job)
  );

  lst_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job_stall (job_stall),
    .job       (job),
    .fade      (fade_r),
    .red       (red_r),
    .green     (green_r),
    .blue      (blue_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: src/lst_div.sv
// ----------------------------------------------------------------------------
// LED star twinkle divider
// Restoring divider, one quotient bit per cycle: q = floor(c*num/den).
// ----------------------------------------------------------------------------
module lst_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [7:0]  chan,
  input  logic [15:0] num,
  input  logic [15:0] den,
  output logic        busy,
  output logic [7:0]  quot
);

  logic [23:0] dvd_r, dvd_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [15:0] den_r, den_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [16:0] shl;

  // One shift and conditional subtract per cycle while busy, one per dividend bit.
  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    shl      = {rem_r[15:0], dvd_r[23]};
    if (start) begin
      dvd_nxt  = 24'(chan) * 24'(num);
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = 5'd24;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (shl >= {1'b0, den_r}) begin
        rem_nxt = shl - {1'b0, den_r};
        dvd_nxt = {dvd_r[22:0], 1'b1};
      end else begin
        rem_nxt = shl;
        dvd_nxt = {dvd_r[22:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign busy = busy_r;
  // The quotient fits in 8 bits since num never exceeds den.
  assign quot = dvd_r[7:0];

endmodule

FILE: src/lst_front.sv
// ----------------------------------------------------------------------------
// LED star twinkle front end
// Accepts frames, spawns stars and classifies each LED into a render job.
// ----------------------------------------------------------------------------
module lst_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  lst_pkg::in_item_t        in_data,
  input  logic [15:0]              fade,
  input  logic [15:0]              hold,
  input  logic [10:0]              thresh,
  input  logic [lst_pkg::LenW-1:0] len,
  output logic                     job_valid,
  input  logic                     job_stall,
  output lst_pkg::job_t            job
);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_CLASS} state_t;

  localparam int LedW = lst_pkg::LedW;

  state_t                     state_r;
  logic [31:0]                now_r;
  logic [LedW-1:0]            idx_r;
  logic [LedW:0]              cnt_r;
  logic [lst_pkg::MaxLeds-1:0] active_r;
  logic                       job_valid_r;
  lst_pkg::job_t              job_r;

  logic [LedW:0]   eff_len;
  logic            spawn;
  logic            ram_we;
  logic [LedW-1:0] ram_addr;
  logic [31:0]     ram_rd;
  logic [31:0]     age;
  logic [17:0]     life;
  logic [16:0]     fh;
  logic            erase;
  logic            job_load;
  logic            cls_full;
  logic [15:0]     cls_num;

  // Length saturates at the strip maximum.
  assign eff_len = (len > lst_pkg::LenW'(lst_pkg::MaxLeds)) ?
                   (LedW+1)'(lst_pkg::MaxLeds) : len[LedW:0];

  assign spawn = in_valid && (state_r == S_IDLE) && ({1'b0, in_data.spawn_draw} < thresh) &&
                 ({1'b0, in_data.spawn_led} < eff_len) && !active_r[in_data.spawn_led];
  assign ram_we   = spawn;
  assign ram_addr = (state_r == S_IDLE) ? in_data.spawn_led : idx_r;

  lst_ram #(.Width(32), .Depth(lst_pkg::MaxLeds)) u_start (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_data.spawn_led),
    .wdata (in_data.frame_ms),
    .raddr (ram_addr),
    .rdata (ram_rd)
  );

  assign in_stall = (state_r != S_IDLE);
  assign age  = now_r - ram_rd;
  assign life = {1'b0, fade, 1'b0} + 18'(hold);
  assign fh   = 17'(fade) + 17'(hold);
  assign erase = active_r[idx_r] && (age >= 32'(life));

  // A job is loaded when the queue slot is free or drains this cycle.
  assign job_load = (state_r == S_CLASS) && (!job_valid_r || !job_stall);

  // Envelope phase of the LED under classification.
  always_comb begin
    cls_full = 1'b0;
    cls_num  = '0;
    if (age < 32'(fade)) begin
      cls_num = age[15:0];
    end else if (age < 32'(fh)) begin
      cls_full = 1'b1;
    end else begin
      cls_num = 16'(life - age[17:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= '0;
      job_valid_r <= 1'b0;
      idx_r       <= '0;
      cnt_r       <= '0;
    end else begin
      if (job_load) begin
        job_valid_r <= 1'b1;
      end else if (!job_stall) begin
        job_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            now_r <= in_data.frame_ms;
            idx_r <= '0;
            cnt_r <= eff_len;
            if (spawn) begin
              active_r[in_data.spawn_led] <= 1'b1;
            end
            if (eff_len != '0) begin
              state_r <= S_READ;
            end
          end
        end
        S_READ: begin
          // Start time read is in flight.
          state_r <= S_CLASS;
        end
        S_CLASS: begin
          if (job_load) begin
            job_r.led  <= idx_r;
            job_r.last <= (cnt_r == (LedW+1)'(1));
            job_r.lit  <= active_r[idx_r] && !erase;
            job_r.full <= cls_full;
            job_r.num  <= cls_num;
            if (erase) begin
              active_r[idx_r] <= 1'b0;
            end
            idx_r <= idx_r + 1'b1;
            cnt_r <= cnt_r - 1'b1;
            state_r <= (cnt_r == (LedW+1)'(1)) ? S_IDLE : S_READ;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign job_valid = job_valid_r;
  assign job       = job_r;

endmodule

FILE: src/lst_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lst_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem_r [Depth];

  // Write and read on the same clock.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

FILE: src/lst_back.sv
// ----------------------------------------------------------------------------
// LED star twinkle back end
// Takes render jobs from the queue, scales the colour and drives results.
// ----------------------------------------------------------------------------
module lst_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid,
  output logic                job_stall,
  input  lst_pkg::job_t       job,
  input  logic [15:0]         fade,
  input  logic [7:0]          red,
  input  logic [7:0]          green,
  input  logic [7:0]          blue,
  output logic                out_valid,
  input  logic                out_stall,
  output lst_pkg::out_item_t  out_data
);

  typedef enum logic [2:0] {S_IDLE, S_R, S_G, S_B, S_DONE, S_OUT} state_t;

  state_t             state_r;
  lst_pkg::job_t      job_r;
  logic [7:0]         r_r, g_r, b_r;
  logic               out_valid_r;
  lst_pkg::out_item_t out_r;
  logic               dstart_r, dstart_nxt;
  logic               div_done;
  logic               out_load;
  logic [7:0]         dchan;
  logic               dbusy;
  logic [7:0]         quot;

  assign job_stall = (state_r != S_IDLE);

  always_comb begin
    case (state_r)
      S_G:     dchan = green;
      S_B:     dchan = blue;
      default: dchan = red;
    endcase
  end

  lst_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dstart_r),
    .chan  (dchan),
    .num   (job_r.num),
    .den   (fade),
    .busy  (dbusy),
    .quot  (quot)
  );

  // The quotient is ready once the start pulse is gone and the divider is idle.
  assign div_done = !dstart_r && !dbusy;
  assign out_load = ((state_r == S_DONE) || (state_r == S_OUT)) &&
                    (!out_valid_r || !out_stall);

  // A divide starts for a new fading job and after each of the first two channels.
  always_comb begin
    dstart_nxt = 1'b0;
    if (state_r == S_IDLE) begin
      dstart_nxt = job_valid && job.lit && !job.full && (fade != '0);
    end else if ((state_r == S_R) || (state_r == S_G)) begin
      dstart_nxt = div_done;
    end
  end

  // Three divides in a row, one per channel, for a fading job; other jobs go straight to output.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      dstart_r    <= 1'b0;
    end else begin
      dstart_r <= dstart_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (job_valid) begin
            job_r   <= job;
            state_r <= dstart_nxt ? S_R : S_OUT;
          end
        end
        S_R: if (div_done) begin
          r_r <= quot; state_r <= S_G;
        end
        S_G: if (div_done) begin
          g_r <= quot; state_r <= S_B;
        end
        S_B: if (div_done) begin
          b_r <= quot; state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            out_r.led_index   <= job_r.led;
            out_r.frame_last  <= job_r.last;
            out_r.pixel_red   <= r_r;
            out_r.pixel_green <= g_r;
            out_r.pixel_blue  <= b_r;
            state_r           <= S_IDLE;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_r.led_index   <= job_r.led;
            out_r.frame_last  <= job_r.last;
            out_r.pixel_red   <= job_r.lit ? red : 8'd0;
            out_r.pixel_green <= job_r.lit ? green : 8'd0;
            out_r.pixel_blue  <= job_r.lit ? blue : 8'd0;
            state_r           <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
